/* design/fxalu_pkg.sv */
// Shared constants, operation codes and saturation helpers for the Q24.8 ALU.
package fxalu_pkg;

  localparam int FRACTION_BITS = 8;
  // Width of the quotient that the divider produces, one bit per stage.
  localparam int QW = 32 + FRACTION_BITS;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [32:0] BIAS33 = (33'd1 << FRACTION_BITS) - 33'd1;
  localparam logic [63:0] BIAS64 = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam logic [QW:0] DIV_POS_LIM = (QW + 1)'(64'd2147483647);
  localparam logic [QW:0] DIV_NEG_LIM = (QW + 1)'(64'd2147483648);

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_EQ       = 4'd4,
    CMD_GT       = 4'd5,
    CMD_LT       = 4'd6,
    CMD_GE       = 4'd7,
    CMD_LE       = 4'd8,
    CMD_MIN      = 4'd9,
    CMD_MAX      = 4'd10,
    CMD_INC      = 4'd11,
    CMD_DEC      = 4'd12,
    CMD_FROM_INT = 4'd13,
    CMD_TO_INT   = 4'd14
  } cmd_t;

  // Returns {overflow, saturated value}.
  function automatic logic [32:0] sat33(input logic [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? S32_MIN : S32_MAX)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat64(input logic [63:0] v);
    logic [32:0] r;
    if ((&v[63:31]) || !(|v[63:31])) begin
      r = {1'b0, v[31:0]};
    end else begin
      r = {1'b1, (v[63] ? S32_MIN : S32_MAX)};
    end
    return r;
  endfunction

endpackage

/* design/fixed_point_alu_q24_8.sv */
// Q24.8 pipeline: input, stage 2, stage 3, divider stages, output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the restoring divider, one quotient bit per stage.
// All operations share the same pipeline so results leave in order.
// Reset (rst, synchronous, active high) clears the valid bits only.
module fixed_point_alu_q24_8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        compare_true,
  output logic        overflow,
  output logic        divide_by_zero
);
  import fxalu_pkg::*;

  logic adv;

  // Stage 1: input registers.
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [31:0] s1_a, s1_b;

  // Stage 2: simple results, product and divider setup.
  logic        s2_valid;
  cmd_t        s2_cmd;
  logic [31:0] s2_res;
  logic        s2_cmp, s2_ovf, s2_dz, s2_neg;
  logic [63:0] s2_prod;
  logic [QW-1:0] s2_num;
  logic [31:0] s2_den;

  // Divider pipe: index 0 is stage 3 (multiply finish), then one entry per quotient bit.
  logic          p_valid [0:QW];
  cmd_t          p_cmd   [0:QW];
  logic [31:0]   p_res   [0:QW];
  logic          p_cmp   [0:QW];
  logic          p_ovf   [0:QW];
  logic          p_dz    [0:QW];
  logic          p_neg   [0:QW];
  logic [31:0]   p_rem   [0:QW];
  logic [QW-1:0] p_num   [0:QW];
  logic [QW-1:0] p_q     [0:QW];
  logic [31:0]   p_den   [0:QW];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_cmd <= cmd_t'(cmd);
      s1_a   <= operand_a;
      s1_b   <= operand_b;
    end
  end

  // Stage 2 logic.
  logic [32:0] a33, b33, sat_v;
  logic [63:0] fi64;
  logic [32:0] ti33;
  logic        lt, eq;
  logic [31:0] res2;
  logic        cmp2, ovf2;

  always_comb begin
    a33   = {s1_a[31], s1_a};
    b33   = {s1_b[31], s1_b};
    lt    = $signed(s1_a) < $signed(s1_b);
    eq    = s1_a == s1_b;
    fi64  = {{32{s1_a[31]}}, s1_a} << FRACTION_BITS;
    ti33  = $signed(a33 + (s1_a[31] ? BIAS33 : 33'd0)) >>> FRACTION_BITS;
    sat_v = 33'd0;
    res2  = 32'd0;
    cmp2  = 1'b0;
    ovf2  = 1'b0;
    unique case (s1_cmd)
      CMD_ADD:      sat_v = sat33(a33 + b33);
      CMD_SUB:      sat_v = sat33(a33 - b33);
      CMD_INC:      sat_v = sat33(a33 + 33'd1);
      CMD_DEC:      sat_v = sat33(a33 - 33'd1);
      CMD_FROM_INT: sat_v = sat64(fi64);
      CMD_TO_INT:   sat_v = {1'b0, ti33[31:0]};
      CMD_MIN:      sat_v = {1'b0, ((!lt && !eq) ? s1_b : s1_a)};
      CMD_MAX:      sat_v = {1'b0, ((!lt && !eq) ? s1_a : s1_b)};
      CMD_EQ:       cmp2 = eq;
      CMD_GT:       cmp2 = !lt && !eq;
      CMD_LT:       cmp2 = lt;
      CMD_GE:       cmp2 = !lt;
      CMD_LE:       cmp2 = lt || eq;
      default:      sat_v = 33'd0;
    endcase
    res2 = sat_v[31:0];
    ovf2 = sat_v[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_cmd  <= s1_cmd;
      s2_res  <= res2;
      s2_cmp  <= cmp2;
      s2_ovf  <= ovf2;
      s2_prod <= 64'($signed(s1_a) * $signed(s1_b));
      s2_dz   <= (s1_cmd == CMD_DIV) && (s1_b == 32'd0);
      s2_neg  <= s1_a[31] ^ s1_b[31];
      s2_num  <= {(s1_a[31] ? (32'd0 - s1_a) : s1_a), {FRACTION_BITS{1'b0}}};
      s2_den  <= s1_b[31] ? (32'd0 - s1_b) : s1_b;
    end
  end

  // Stage 3: product truncated toward zero, then saturated.
  logic [63:0] mul_sh;
  logic [32:0] mul_sat;

  always_comb begin
    mul_sh  = $signed(s2_prod + (s2_prod[63] ? BIAS64 : 64'd0)) >>> FRACTION_BITS;
    mul_sat = sat64(mul_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid[0] <= 1'b0;
    end else if (adv) begin
      p_valid[0] <= s2_valid;
    end
    if (adv) begin
      p_cmd[0] <= s2_cmd;
      p_res[0] <= (s2_cmd == CMD_MUL) ? mul_sat[31:0] : s2_res;
      p_ovf[0] <= (s2_cmd == CMD_MUL) ? mul_sat[32] : s2_ovf;
      p_cmp[0] <= s2_cmp;
      p_dz[0]  <= s2_dz;
      p_neg[0] <= s2_neg;
      p_rem[0] <= 32'd0;
      p_num[0] <= s2_num;
      p_q[0]   <= '0;
      p_den[0] <= s2_den;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [32:0] rem_sh;
    logic        ge;

    always_comb begin
      rem_sh = {p_rem[k], p_num[k][QW-1]};
      ge     = rem_sh >= {1'b0, p_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        p_valid[k+1] <= 1'b0;
      end else if (adv) begin
        p_valid[k+1] <= p_valid[k];
      end
      if (adv) begin
        p_cmd[k+1] <= p_cmd[k];
        p_res[k+1] <= p_res[k];
        p_ovf[k+1] <= p_ovf[k];
        p_cmp[k+1] <= p_cmp[k];
        p_dz[k+1]  <= p_dz[k];
        p_neg[k+1] <= p_neg[k];
        p_den[k+1] <= p_den[k];
        p_num[k+1] <= p_num[k] << 1;
        p_q[k+1]   <= {p_q[k][QW-2:0], ge};
        p_rem[k+1] <= ge ? 32'(rem_sh - {1'b0, p_den[k]}) : rem_sh[31:0];
      end
    end
  end

  // Final stage: rounding half away from zero and saturation of the quotient.
  logic [QW:0] qr;
  logic [31:0] res_f;
  logic        ovf_f;

  always_comb begin
    qr    = {1'b0, p_q[QW]} +
            (QW + 1)'({p_rem[QW], 1'b0} >= {1'b0, p_den[QW]});
    res_f = p_res[QW];
    ovf_f = p_ovf[QW];
    if (p_cmd[QW] == CMD_DIV) begin
      if (p_dz[QW]) begin
        res_f = 32'd0;
        ovf_f = 1'b0;
      end else if (p_neg[QW]) begin
        ovf_f = qr > DIV_NEG_LIM;
        res_f = ovf_f ? S32_MIN : (32'd0 - qr[31:0]);
      end else begin
        ovf_f = qr > DIV_POS_LIM;
        res_f = ovf_f ? S32_MAX : qr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid[QW];
    end
    if (adv) begin
      result_value   <= res_f;
      overflow       <= ovf_f;
      compare_true   <= p_cmp[QW];
      divide_by_zero <= p_dz[QW];
    end
  end

endmodule

/* design/fxalu_checker.sv */
// Port-level checker for the fixed-point ALU and its bind.
module fxalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_value,
  input logic        compare_true,
  input logic        overflow,
  input logic        divide_by_zero
);
  import fxalu_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compare_true) |-> (result_value == 32'd0 && !overflow && !divide_by_zero))
    else $error("comparison beat carries a value or a flag");

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (result_value == 32'd0 && !overflow))
    else $error("divide by zero beat not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_value) && $stable(overflow)))
    else $error("stalled result beat changed");

endmodule

bind fixed_point_alu_q24_8 fxalu_checker u_fxalu_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .result_value(result_value), .compare_true(compare_true),
  .overflow(overflow), .divide_by_zero(divide_by_zero)
);

/* dv/testbench.sv */
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random beats.
`timescale 1ns / 100ps

module testbench;
  import fxalu_pkg::*;

  localparam int LATENCY = FRACTION_BITS + 35;
  localparam logic [3:0] CMD_UNUSED = 4'd15;

  typedef struct {
    logic [31:0] value;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    static function logic [31:0] clamp32(longint v, ref logic ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        return S32_MAX;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        return S32_MIN;
      end
      return v[31:0];
    endfunction

    // Exact quotient a * 2^F / b, rounded half away from zero.
    static function logic [31:0] round_div(longint a, longint b, ref logic ovf);
      logic [63:0] num, den, q, r;
      logic        neg;
      num = (a < 0 ? -a : a) << FRACTION_BITS;
      den = b < 0 ? -b : b;
      q = num / den;
      r = num % den;
      neg = (a < 0) != (b < 0);
      if (2 * r >= den) q++;
      if (neg) begin
        if (q > 64'd2147483648) begin
          ovf = 1'b1;
          return S32_MIN;
        end
        return 32'(-q);
      end
      if (q > 64'd2147483647) begin
        ovf = 1'b1;
        return S32_MAX;
      end
      return q[31:0];
    endfunction

    function void note_operation(logic [3:0] op, logic [31:0] ra, logic [31:0] rb);
      alu_result_t e;
      longint a, b, scale;
      a = longint'(signed'(ra));
      b = longint'(signed'(rb));
      scale = longint'(1) << FRACTION_BITS;
      e.value = '0;
      e.cmp = 1'b0;
      e.ovf = 1'b0;
      e.dz = 1'b0;
      case (op)
        CMD_ADD:      e.value = clamp32(a + b, e.ovf);
        CMD_SUB:      e.value = clamp32(a - b, e.ovf);
        CMD_MUL:      e.value = clamp32((a * b) / scale, e.ovf);
        CMD_DIV: begin
          if (b == 0) e.dz = 1'b1;
          else e.value = round_div(a, b, e.ovf);
        end
        CMD_EQ:       e.cmp = a == b;
        CMD_GT:       e.cmp = a > b;
        CMD_LT:       e.cmp = a < b;
        CMD_GE:       e.cmp = a >= b;
        CMD_LE:       e.cmp = a <= b;
        CMD_MIN:      e.value = (a > b) ? rb : ra;
        CMD_MAX:      e.value = (a > b) ? ra : rb;
        CMD_INC:      e.value = clamp32(a + 1, e.ovf);
        CMD_DEC:      e.value = clamp32(a - 1, e.ovf);
        CMD_FROM_INT: e.value = clamp32(a * scale, e.ovf);
        CMD_TO_INT:   e.value = 32'(a / scale);
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] v, logic c, logic o, logic d);
      alu_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat value=%h", $time, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        $display("%0t: result_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (c !== e.cmp) begin
        $display("%0t: compare_true expected %b actual %b", $time, e.cmp, c);
        errors++;
      end
      if (o !== e.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, e.ovf, o);
        errors++;
      end
      if (d !== e.dz) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  cmd = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_value;
  logic        compare_true;
  logic        overflow;
  logic        divide_by_zero;

  alu_scoreboard alu_sb = new();
  bit            stall_quiet = 1'b0;

  fixed_point_alu_q24_8 u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      alu_sb.check_result(result_value, compare_true, overflow, divide_by_zero);
    end
  end

  // Receiver stall pattern: alternating calm and busy periods.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (stall_quiet || (phase % 600) < 150) out_stall <= 1'b0;
      else if ((phase % 600) < 300) out_stall <= ($urandom_range(0, 9) < 7);
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Drives one beat; valid stays high when the next beat follows directly.
  // Otherwise valid drops low between this beat and the next.
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit keep);
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    alu_sb.note_operation(op, a, b);
    @(negedge clk);
    if (!keep) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return S32_MAX - $urandom_range(0, 3);
      1: return S32_MIN + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      3: return 32'(signed'($urandom_range(0, 65535)) - 32768) <<< $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (alu_sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [3:0] op;
    logic [31:0] a, b;
    int burst;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats: extremes, every operation, divide by zero, unused code.
    send_op(CMD_ADD, S32_MAX, 32'd1, 0);
    send_op(CMD_SUB, S32_MIN, 32'd1, 0);
    send_op(CMD_MUL, S32_MAX, S32_MAX, 0);
    send_op(CMD_MUL, S32_MIN, S32_MAX, 0);
    send_op(CMD_MUL, 32'hffff_ff01, 32'd1, 0);
    send_op(CMD_DIV, 32'd256, 32'd0, 0);
    send_op(CMD_DIV, S32_MIN, 32'hffff_ffff, 0);
    send_op(CMD_DIV, S32_MAX, 32'd1, 0);
    send_op(CMD_DIV, 32'd1, 32'd512, 0);
    send_op(CMD_DIV, 32'hffff_ffff, 32'd512, 0);
    send_op(CMD_EQ, S32_MIN, S32_MIN, 0);
    send_op(CMD_GT, S32_MAX, S32_MIN, 0);
    send_op(CMD_LT, S32_MIN, S32_MAX, 0);
    send_op(CMD_GE, 32'd5, 32'd5, 0);
    send_op(CMD_LE, 32'd6, 32'd5, 0);
    send_op(CMD_MIN, S32_MAX, S32_MIN, 0);
    send_op(CMD_MAX, S32_MAX, S32_MIN, 0);
    send_op(CMD_INC, S32_MAX, 32'd0, 0);
    send_op(CMD_DEC, S32_MIN, 32'hffff_ffff, 0);
    send_op(CMD_FROM_INT, 32'h0080_0000, 32'd0, 0);
    send_op(CMD_FROM_INT, 32'hff7f_ffff, 32'd0, 0);
    send_op(CMD_TO_INT, S32_MIN, 32'd0, 0);
    send_op(CMD_TO_INT, 32'hffff_ff01, 32'd0, 0);
    send_op(CMD_UNUSED, S32_MAX, S32_MIN, 0);

    // The sender holds off here until the pipeline has emptied.
    drain();

    for (int n = 0; n < 850; n += burst) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++) begin
        op = ($urandom_range(0, 40) == 0) ? CMD_UNUSED : 4'($urandom_range(0, 14));
        a = pick_operand();
        b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
        if ($urandom_range(0, 7) == 0) b = a;
        send_op(op, a, b, k != burst - 1);
      end
      if (n > 400 && n < 430) begin
        stall_quiet = 1'b1;
        drain();
        stall_quiet = 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end

    stall_quiet = 1'b1;
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (alu_sb.errors == 0 && alu_sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

/* fixed_point_alu_q24_8.f */
design/fxalu_pkg.sv
design/fixed_point_alu_q24_8.sv
design/fxalu_checker.sv
dv/testbench.sv
